[sv/stream_find_replace_core_defines.svh]
// Assertion macros for the stream find/replace core.
// No dependencies; included by the files that carry assertions.
`ifndef STREAM_FIND_REPLACE_CORE_DEFINES_SVH
`define STREAM_FIND_REPLACE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check with reset masking.
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that also holds while reset is applied.
`define SFR_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFR_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[sv/sfr_pkg.sv]
// Shared constants, types and helpers of the stream find/replace core.
// No dependencies.
package sfr_pkg;

  localparam int unsigned PATTERN_MAX = 8;
  localparam int unsigned REPLACE_MAX = 8;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned COUNT_W     = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CMD_DEPTH   = 4;
  localparam int unsigned CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN,
    REG_FIND_LEN,
    REG_REPLACEMENT,
    REG_REPLACE_LEN,
    REG_MATCH_CASE
  } cfg_reg_e;

  typedef logic [PATTERN_MAX-1:0][7:0] win_t;
  typedef logic [REPLACE_MAX-1:0][7:0] rep_t;

  typedef struct packed {
    win_t             pattern;
    logic [LEN_W-1:0] find_len;
    logic             match_case;
  } match_cfg_t;

  typedef struct packed {
    rep_t             bytes;
    logic [LEN_W-1:0] len;
  } repl_cfg_t;

  // One classified input word, as handed from front to back.
  typedef struct packed {
    logic               is_repl;
    win_t               bytes;
    logic [LEN_W-1:0]   nbytes;
    logic               last;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v,
                                                 logic [LEN_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

[sv/stream_find_replace_core.sv]
// Top level of the stream find/replace core: configuration registers,
// front end, command queue and back end. Depends on sfr_pkg and all sfr_ modules.
//
//  channel   direction  handshake         fields
//  --------  ---------  ----------------  ------------------------------------------
//  input     in         push_i / full_o   in_byte_i, in_last_i
//  result    out        pop_i / empty_o   out_byte_o, byte_valid_o, out_last_o,
//                                         match_count_o
//  config    in         cfg_we_i          cfg_idx_i, cfg_data_i
//
//  Input: one byte a cycle while the command queue has room; the front end
//  classifies each byte in the cycle it is accepted.
//  Results: one word a cycle from the back end while the receiver pops; a byte
//  that causes k words holds the back end until all k are out (an empty command gives none).
//  The first word of a byte passes through the command queue and then the result
//  register before it is on the result ports, where it can be popped.
//  Reset clears the window fill, the count, the queue and the result valid flag;
//  no clearing pass is needed.
//  Output stalls fill the queue, and full_o then holds the input side.
module stream_find_replace_core import sfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  // result words
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [7:0]            out_byte_o,
  output logic                  byte_valid_o,
  output logic                  out_last_o,
  output logic [COUNT_W-1:0]    match_count_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  match_cfg_t mcfg_q;
  repl_cfg_t  rcfg_q;
  logic       clr_fill;
  logic       accept;
  cmd_t       front_cmd, head_cmd;
  logic       front_push, head_valid, head_pop;

  // Writing the pattern length drops any pending window bytes.
  assign clr_fill = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_FIND_LEN);
  assign accept   = push_i && !full_o;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcfg_q.pattern    <= '0;
      mcfg_q.find_len   <= '0;
      mcfg_q.match_case <= 1'b1;
      rcfg_q.bytes      <= '0;
      rcfg_q.len        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PATTERN:     mcfg_q.pattern    <= win_t'(cfg_data_i[8*PATTERN_MAX-1:0]);
        REG_FIND_LEN:    mcfg_q.find_len   <= cfg_data_i[LEN_W-1:0];
        REG_REPLACEMENT: rcfg_q.bytes      <= rep_t'(cfg_data_i[8*REPLACE_MAX-1:0]);
        REG_REPLACE_LEN: rcfg_q.len        <= cfg_data_i[LEN_W-1:0];
        REG_MATCH_CASE:  mcfg_q.match_case <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Classify each accepted byte.
  sfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (mcfg_q),
    .clr_i      (clr_fill),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .cmd_o      (front_cmd),
    .cmd_push_o (front_push)
  );

  // Decouple classification from expansion.
  sfr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (full_o),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  // Expand commands into result words.
  sfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (rcfg_q),
    .cmd_i         (head_cmd),
    .cmd_valid_i   (head_valid),
    .cmd_pop_o     (head_pop),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .out_last_o    (out_last_o),
    .match_count_o (match_count_o),
    .empty_o       (empty_o),
    .pop_i         (pop_i)
  );

endmodule

[sv/sfr_front.sv]
// Front end: match window, pattern compare and replacement count.
// Depends on sfr_pkg; emits one command word per accepted byte at most.
`include "stream_find_replace_core_defines.svh"
module sfr_front import sfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  match_cfg_t cfg_i,
  input  logic       clr_i,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output cmd_t       cmd_o,
  output logic       cmd_push_o
);

  function automatic logic [7:0] fold(logic [7:0] c, logic mc);
    return (!mc && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  win_t               win_q, win_d, win_w;
  logic [LEN_W-1:0]   fill_q, fill_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic [LEN_W-1:0]   len, pos_fill, nfill;
  logic               hit;

  always_comb begin
    len      = clamp_len(cfg_i.find_len, LEN_W'(PATTERN_MAX));
    pos_fill = (fill_q >= len) ? len - LEN_W'(1) : fill_q;
    win_w    = win_q;
    win_w[pos_fill[POS_W-1:0]] = in_byte_i;
    nfill    = pos_fill + LEN_W'(1);
    hit      = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < len &&
          fold(win_w[i], cfg_i.match_case) != fold(cfg_i.pattern[i], cfg_i.match_case)) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    win_d      = win_q;
    fill_d     = fill_q;
    cnt_n      = cnt_q;
    cmd_push_o = 1'b0;
    cmd_o          = '0;
    cmd_o.bytes    = win_w;
    cmd_o.last     = in_last_i;
    if (len == '0) begin
      // Pass through.
      cmd_o.bytes    = '0;
      cmd_o.bytes[0] = in_byte_i;
      cmd_o.nbytes   = LEN_W'(1);
      cmd_push_o     = 1'b1;
      fill_d         = '0;
    end else if (nfill == len) begin
      if (hit) begin
        cmd_o.is_repl = 1'b1;
        cmd_push_o    = 1'b1;
        cnt_n         = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);
        fill_d        = '0;
      end else begin
        // Emit oldest byte, or the whole window at end of text.
        cmd_o.nbytes = in_last_i ? len : LEN_W'(1);
        cmd_push_o   = 1'b1;
        win_d        = win_t'({8'h00, win_w[PATTERN_MAX-1:1]});
        fill_d       = len - LEN_W'(1);
      end
    end else begin
      cmd_o.nbytes = nfill;
      cmd_push_o   = in_last_i;
      win_d        = win_w;
      fill_d       = nfill;
    end
    cmd_o.count = cnt_n;
    cnt_d       = cnt_n;
    if (in_last_i) begin
      fill_d = '0;
      cnt_d  = '0;
    end
    if (!accept_i) begin
      cmd_push_o = 1'b0;
      win_d      = win_q;
      fill_d     = fill_q;
      cnt_d      = cnt_q;
    end
    if (clr_i) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  `SFR_ASSERT(a_fill_below_len, clk_i, rst_ni, (fill_q < len) || (len == '0 && fill_q == '0), "window fill not below pattern length")

endmodule

[sv/sfr_cmd_fifo.sv]
// Short command queue between front and back ends.
// Depends on sfr_pkg for the command type and depth.
`include "stream_find_replace_core_defines.svh"
module sfr_cmd_fifo import sfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CMD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SFR_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CMD_CNT_W'(CMD_DEPTH), "queue count above depth")
  `SFR_ASSERT(a_ptr_match, clk_i, rst_ni, (cnt_q == '0 || full_o) |-> (wr_ptr_q == rd_ptr_q), "queue pointers disagree with count")

endmodule

[sv/sfr_back.sv]
// Back end: expands command words into result words, one per cycle while the output slot is free.
// Depends on sfr_pkg; holds the result register seen on the output ports.
`include "stream_find_replace_core_defines.svh"
module sfr_back import sfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  repl_cfg_t          cfg_i,
  input  cmd_t               cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               out_last_o,
  output logic [COUNT_W-1:0] match_count_o,
  output logic               empty_o,
  input  logic               pop_i
);

  logic [LEN_W-1:0]   idx_q, idx_d, data_len;
  logic               out_valid_q;
  logic [7:0]         byte_q, word_byte;
  logic               bvalid_q, last_q;
  logic [COUNT_W-1:0] count_q;
  logic               in_data, has_word, slot_free, step, final_word;

  always_comb begin
    data_len   = cmd_i.is_repl ? clamp_len(cfg_i.len, LEN_W'(REPLACE_MAX)) : cmd_i.nbytes;
    in_data    = idx_q < data_len;
    has_word   = in_data || cmd_i.last;
    slot_free  = !out_valid_q || pop_i;
    // An empty command (zero-length replacement mid-text) is dropped without waiting for a free output slot.
    step       = cmd_valid_i && (slot_free || !has_word);
    final_word = in_data ? ((idx_q + LEN_W'(1) == data_len) && !cmd_i.last) : 1'b1;
    cmd_pop_o  = step && final_word;
    idx_d      = idx_q;
    if (step) begin
      idx_d = final_word ? '0 : idx_q + LEN_W'(1);
    end
    word_byte = cmd_i.is_repl ? cfg_i.bytes[idx_q[POS_W-1:0]] : cmd_i.bytes[idx_q[POS_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (step && has_word) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_word) begin
      if (in_data) begin
        byte_q   <= word_byte;
        bvalid_q <= 1'b1;
        last_q   <= 1'b0;
        count_q  <= '0;
      end else begin
        byte_q   <= 8'h00;
        bvalid_q <= 1'b0;
        last_q   <= 1'b1;
        count_q  <= cmd_i.count;
      end
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bvalid_q;
  assign out_last_o    = last_q;
  assign match_count_o = count_q;

  `SFR_ASSERT(a_idx_idle, clk_i, rst_ni, !cmd_valid_i |-> (idx_q == '0), "word index not cleared between commands")
  `SFR_ASSERT(a_idx_range, clk_i, rst_ni, cmd_valid_i |-> (idx_q < data_len || (idx_q == data_len && (cmd_i.last || idx_q == '0))), "word index past command end")

endmodule

[tb/testbench.sv]
// Self-checking testbench for stream_find_replace_core: byte streams with
// random stalls on both sides, checked word by word against a predictor.
// Depends on sfr_pkg and the RTL of the core.
module testbench;
  import sfr_pkg::*;

  localparam int unsigned HOLD_CYCLES = 90;   // long output hold-off that fills the queue
  localparam int unsigned SETTLE_TAIL = 16;   // cycles to let the back end go quiet
  localparam int unsigned BYTES_WANTED = 450;
  localparam int unsigned CALM_FROM = 380;    // no idling once this many bytes have gone in
  localparam logic [63:0] EDGE_PATTERN = 64'h00FF_807F_5A41_7A61;

  // Mirror of the core: configuration, window and count, plus the words still owed.
  class sfr_scoreboard;
    typedef struct {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic               out_last;
      logic [COUNT_W-1:0] match_count;
    } word_t;

    word_t              awaited_words[$];
    logic [63:0]        pat_bytes;
    logic [63:0]        rep_bytes;
    logic [3:0]         find_len;
    logic [3:0]         rep_len;
    logic               exact;
    logic [7:0]         window[PATTERN_MAX];
    int unsigned        fill;
    logic [COUNT_W-1:0] hits;
    int unsigned        errors;
    int unsigned        words_checked;
    int unsigned        replacements;

    function new();
      pat_bytes = '0;
      rep_bytes = '0;
      find_len = '0;
      rep_len = '0;
      exact = 1'b1;
      foreach (window[i]) window[i] = '0;
      fill = 0;
      hits = '0;
      errors = 0;
      words_checked = 0;
      replacements = 0;
    endfunction

    function logic [7:0] fold(logic [7:0] c);
      if (!exact && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
      return c;
    endfunction

    function void owe(logic [7:0] b, logic v, logic l, logic [COUNT_W-1:0] c);
      word_t w;
      w.out_byte = b;
      w.byte_valid = v;
      w.out_last = l;
      w.match_count = c;
      awaited_words.push_back(w);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] v);
      case (idx)
        REG_PATTERN:     pat_bytes = v;
        REG_FIND_LEN: begin
          find_len = v[3:0];
          fill = 0;   // a length change drops pending bytes
        end
        REG_REPLACEMENT: rep_bytes = v;
        REG_REPLACE_LEN: rep_len = v[3:0];
        REG_MATCH_CASE:  exact = v[0];
        default: ;
      endcase
    endfunction

    // Work out the words one accepted byte causes.
    function void note_byte(logic [7:0] b, logic last);
      int unsigned len;
      int unsigned rlen;
      bit hit;
      len = (find_len > PATTERN_MAX) ? PATTERN_MAX : find_len;
      rlen = (rep_len > REPLACE_MAX) ? REPLACE_MAX : rep_len;
      if (len == 0) begin
        fill = 0;
        owe(b, 1'b1, 1'b0, '0);
      end else begin
        if (fill >= len) fill = len - 1;
        window[fill] = b;
        fill++;
        if (fill == len) begin
          hit = 1'b1;
          for (int i = 0; i < len; i++)
            if (fold(window[i]) != fold(pat_bytes[8*i +: 8])) hit = 1'b0;
          if (hit) begin
            for (int i = 0; i < rlen; i++) owe(rep_bytes[8*i +: 8], 1'b1, 1'b0, '0);
            fill = 0;
            replacements++;
            if (hits != COUNT_MAX) hits++;
          end else begin
            owe(window[0], 1'b1, 1'b0, '0);
            for (int i = 1; i < len; i++) window[i-1] = window[i];
            fill = len - 1;
          end
        end
      end
      if (last) begin
        for (int i = 0; i < fill; i++) owe(window[i], 1'b1, 1'b0, '0);
        fill = 0;
        owe(8'h00, 1'b0, 1'b1, hits);
        hits = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("word %0d: %s", words_checked, msg);
    endtask

    task check_word(logic [7:0] b, logic v, logic l, logic [COUNT_W-1:0] c);
      word_t w;
      words_checked++;
      if (awaited_words.size() == 0) begin
        report($sformatf("unexpected word byte 0x%0h valid %0b last %0b", b, v, l));
        return;
      end
      w = awaited_words.pop_front();
      if (b !== w.out_byte)
        report($sformatf("out_byte 0x%0h, expected 0x%0h", b, w.out_byte));
      if (v !== w.byte_valid)
        report($sformatf("byte_valid %0b, expected %0b", v, w.byte_valid));
      if (l !== w.out_last)
        report($sformatf("out_last %0b, expected %0b", l, w.out_last));
      if (c !== w.match_count)
        report($sformatf("match_count %0d, expected %0d", c, w.match_count));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push_i = 1'b0;
  logic                  full_o;
  logic [7:0]            in_byte_i = '0;
  logic                  in_last_i = 1'b0;
  logic                  empty_o;
  logic                  pop_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  byte_valid_o;
  logic                  out_last_o;
  logic [COUNT_W-1:0]    match_count_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sfr_scoreboard sb = new();
  bit          idle_on = 1'b1;   // random stalls on both sides
  bit          hold_req = 1'b0;  // ask the receiver for one long hold-off
  int unsigned bytes_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned settings_used = 0;

  stream_find_replace_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .out_last_o    (out_last_o),
    .match_count_o (match_count_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // Offer one byte from the falling edge and hold it until a rising edge takes it.
  task automatic push_word(logic [7:0] b, logic last);
    @(negedge clk_i);
    push_i <= 1'b1;
    in_byte_i <= b;
    in_last_i <= last;
    do @(posedge clk_i); while (full_o !== 1'b0);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // Send a run of bytes, with random gaps; mark the final one when the text ends here.
  task automatic send_text(logic [7:0] txt[$], bit ends);
    int unsigned n;
    foreach (txt[i]) begin
      if (idle_on && $urandom_range(0, 11) == 0) begin
        n = $urandom_range(1, 18);
        repeat (n) begin
          @(negedge clk_i);
          push_i <= 1'b0;
        end
      end
      push_word(txt[i], ends && (i == txt.size() - 1));
    end
    if (ends) texts_sent++;
  endtask

  // Drop push, wait for every owed word, then let the back end go quiet.
  task automatic settle();
    @(negedge clk_i);
    push_i <= 1'b0;
    while (sb.awaited_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TAIL) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [63:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [63:0] pat, logic [3:0] flen, logic [63:0] rep,
                           logic [3:0] rlen, logic mc);
    cfg_write(REG_PATTERN, pat);
    cfg_write(REG_FIND_LEN, {60'd0, flen});
    cfg_write(REG_REPLACEMENT, rep);
    cfg_write(REG_REPLACE_LEN, {60'd0, rlen});
    cfg_write(REG_MATCH_CASE, {63'd0, mc});
    settings_used++;
  endtask

  // Flip the case of a letter now and then, to give near misses and folded hits.
  function automatic logic [7:0] maybe_flip(logic [7:0] c);
    if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 2) == 0)
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [3:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(2, 7));
    endcase
  endfunction

  // Mostly copies of the pattern, whole or cut short, mixed with its bytes and noise.
  function automatic void make_text(output logic [7:0] txt[$]);
    int unsigned target;
    int unsigned len;
    int unsigned k;
    int unsigned r;
    txt = {};
    target = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
    len = (sb.find_len > PATTERN_MAX) ? PATTERN_MAX : sb.find_len;
    while (txt.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 40 && len > 0) begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
        for (int j = 0; j < k; j++) txt.push_back(maybe_flip(sb.pat_bytes[8*j +: 8]));
      end else if (r < 60) begin
        txt.push_back(maybe_flip(sb.pat_bytes[8*$urandom_range(0, 7) +: 8]));
      end else begin
        txt.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  function automatic logic [63:0] make_pattern();
    logic [63:0] p;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: p[8*i +: 8] = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
        5: p[8*i +: 8] = 8'h00;
        6: p[8*i +: 8] = 8'hFF;
        default: p[8*i +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  // Receiver: pop from the falling edge, check at the rising edge.
  initial begin : drain_results
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        // hold off for a long stretch so that the queue fills and full_o stalls the input
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          pop_i <= 1'b0;
        end
        hold_req = 1'b0;
      end
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop_i <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        pop_i <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        pop_i <= 1'b1;
      end
      @(posedge clk_i);
      if (pop_i === 1'b1 && empty_o === 1'b0)
        sb.check_word(out_byte_o, byte_valid_o, out_last_o, match_count_o);
    end
  end

  // Main sequence: reset, directed cases, random phases, drain and verdict.
  initial begin : stimulus
    logic [7:0] txt[$];
    int unsigned n_texts;
    bit first_random;
    first_random = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: zero pattern length, so bytes pass straight through.
    txt = '{8'h00, 8'hFF, 8'h41};
    send_text(txt, 1'b1);
    settle();

    // Case-insensitive two-byte pattern with letters at the fold boundaries nearby.
    configure(64'hDEAD_BEEF_CAFE_4261, 4'd2, 64'h1122_3344_555A_5958, 4'd3, 1'b0);
    txt = '{8'h41, 8'h62, 8'h40, 8'h61, 8'h42, 8'h5B};
    send_text(txt, 1'b1);
    settle();

    // Oversized lengths clamp; a length write mid-text drops the pending window.
    configure(EDGE_PATTERN, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd12, 1'b1);
    txt = '{EDGE_PATTERN[7:0], EDGE_PATTERN[15:8], EDGE_PATTERN[23:16]};
    send_text(txt, 1'b0);
    settle();
    cfg_write(REG_FIND_LEN, 64'd3);
    send_text(txt, 1'b1);
    settle();

    // Longest pattern replaced by nothing.
    cfg_write(REG_FIND_LEN, 64'd8);
    cfg_write(REG_REPLACE_LEN, 64'd0);
    txt = {};
    for (int i = 0; i < 8; i++) txt.push_back(EDGE_PATTERN[8*i +: 8]);
    send_text(txt, 1'b1);
    settle();

    // Random phases: fresh settings, then a handful of texts each.
    while (bytes_sent < BYTES_WANTED) begin
      if (bytes_sent >= CALM_FROM) idle_on = 1'b0;
      configure(make_pattern(), pick_len(), {$urandom, $urandom}, pick_len(),
                1'($urandom_range(0, 1)));
      if (first_random) hold_req = 1'b1;
      first_random = 1'b0;
      n_texts = $urandom_range(2, 6);
      repeat (n_texts) begin
        make_text(txt);
        send_text(txt, 1'b1);
      end
      settle();
    end

    // Match-count saturation needs far more matches in one text than a run of this length holds.
    $display("Sent %0d bytes in %0d texts under %0d register settings.",
             bytes_sent, texts_sent, settings_used);
    $display("Checked %0d result words, %0d replacements among them.",
             sb.words_checked, sb.replacements);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
